### sv/dsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door sequencer package
// Operation, door state and slot codes, and the structs passed between the
// queue, the door state logic and the top level.
// ----------------------------------------------------------------------------
package dsq_pkg;

   localparam int OP_W    = 2;
   localparam int STATE_W = 3;
   localparam int TICKS_W = 8;
   localparam int SLOT_W  = 2;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 2;
   localparam int CSR_W   = 2;

   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
   localparam logic [OP_W-1:0] OP_SET  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ = 2'd3;

   localparam logic [STATE_W-1:0] ST_CLOSED  = 3'd0;
   localparam logic [STATE_W-1:0] ST_OPENING = 3'd1;
   localparam logic [STATE_W-1:0] ST_OPEN    = 3'd2;
   localparam logic [STATE_W-1:0] ST_CLOSING = 3'd3;
   localparam logic [STATE_W-1:0] ST_UNKNOWN = 3'd4;

   localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_CLOSE = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_OPEN  = 2'd2;

   localparam logic [CSR_W-1:0] CSR_OPENING_TICKS = 2'd0;
   localparam logic [CSR_W-1:0] CSR_OPEN_TICKS    = 2'd1;
   localparam logic [CSR_W-1:0] CSR_CLOSING_TICKS = 2'd2;

   localparam logic [TICKS_W-1:0] OPENING_TICKS_RST = 8'd3;
   localparam logic [TICKS_W-1:0] OPEN_TICKS_RST    = 8'd2;
   localparam logic [TICKS_W-1:0] CLOSING_TICKS_RST = 8'd2;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic tick;
      logic add;
      logic set;
      logic read;
   } ctrl_type;

   typedef struct packed {
      logic valid;
      logic is_open;
   } head_type;

endpackage
`default_nettype wire

### sv/door_sequencer_with_command_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door sequencer with command queue
// Tick, add, set and read transactions on a door state machine fed by a
// deduplicating open/close command queue.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  operation, command, new_state,
//                                             entry_index
//  rsp      out        rsp_valid / rsp_ready  door_state, queue_count,
//                                             entry_value
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
//  One transaction per cycle while rsp_ready is high: input register, then
//  queue and state logic into the result register. No clearing pass; reset
//  sets state unknown, clears counters and queue, loads tick CSR defaults.
//  rsp_ready low holds the result; the input register still fills, then
//  req_ready drops until the result is taken. csr_ready is always high.
// ----------------------------------------------------------------------------
module door_sequencer_with_command_queue_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [dsq_pkg::CSR_W-1:0]    csr_index,
   input  wire logic [dsq_pkg::TICKS_W-1:0]  csr_data,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [dsq_pkg::OP_W-1:0]     req_operation,
   input  wire logic                         req_command,
   input  wire logic [dsq_pkg::STATE_W-1:0]  req_new_state,
   input  wire logic [dsq_pkg::INDEX_W-1:0]  req_entry_index,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [dsq_pkg::STATE_W-1:0]  rsp_door_state,
   output logic      [dsq_pkg::COUNT_W-1:0]  rsp_queue_count,
   output logic      [dsq_pkg::SLOT_W-1:0]   rsp_entry_value
);

   logic [dsq_pkg::TICKS_W-1:0] opening_ticks_ff;
   logic [dsq_pkg::TICKS_W-1:0] open_ticks_ff;
   logic [dsq_pkg::TICKS_W-1:0] closing_ticks_ff;

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [dsq_pkg::OP_W-1:0]     s1_op_ff;
   logic                         s1_cmd_ff;
   logic [dsq_pkg::STATE_W-1:0]  s1_state_ff;
   logic [dsq_pkg::INDEX_W-1:0]  s1_index_ff;
   logic                         s1_go;
   logic                         req_take;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [dsq_pkg::STATE_W-1:0]  rsp_state_ff;
   logic [dsq_pkg::COUNT_W-1:0]  rsp_count_ff;
   dsq_pkg::slot_type            rsp_entry_ff;

   dsq_pkg::ctrl_type            ctrl;
   dsq_pkg::head_type            head;
   logic [dsq_pkg::STATE_W-1:0]  state_next;
   logic [dsq_pkg::COUNT_W-1:0]  count_next;
   dsq_pkg::slot_type            entry_value;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         opening_ticks_ff <= dsq_pkg::OPENING_TICKS_RST;
         open_ticks_ff    <= dsq_pkg::OPEN_TICKS_RST;
         closing_ticks_ff <= dsq_pkg::CLOSING_TICKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            dsq_pkg::CSR_OPENING_TICKS: opening_ticks_ff <= csr_data;
            dsq_pkg::CSR_OPEN_TICKS:    open_ticks_ff    <= csr_data;
            dsq_pkg::CSR_CLOSING_TICKS: closing_ticks_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign s1_go        = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_go;
   assign req_take     = req_valid && req_ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_operation;
         s1_cmd_ff   <= req_command;
         s1_state_ff <= req_new_state;
         s1_index_ff <= req_entry_index;
      end
      if (s1_go) begin
         rsp_state_ff <= state_next;
         rsp_count_ff <= count_next;
         rsp_entry_ff <= entry_value;
      end
   end

   always_comb begin
      ctrl = '0;
      if (s1_go) begin
         unique case (s1_op_ff)
            dsq_pkg::OP_TICK: ctrl.tick = 1'b1;
            dsq_pkg::OP_ADD:  ctrl.add  = 1'b1;
            dsq_pkg::OP_SET:  ctrl.set  = 1'b1;
            dsq_pkg::OP_READ: ctrl.read = 1'b1;
            default:          ctrl      = '0;
         endcase
      end
   end

   dsq_cmd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .command     (s1_cmd_ff),
      .entry_index (s1_index_ff),
      .head        (head),
      .count_next  (count_next),
      .entry_value (entry_value)
   );

   dsq_door_fsm u_door (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .head          (head),
      .new_state     (s1_state_ff),
      .opening_ticks (opening_ticks_ff),
      .open_ticks    (open_ticks_ff),
      .closing_ticks (closing_ticks_ff),
      .state_next    (state_next)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_door_state  = rsp_state_ff;
   assign rsp_queue_count = rsp_count_ff;
   assign rsp_entry_value = rsp_entry_ff;

endmodule
`default_nettype wire

### sv/dsq_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door sequencer command queue
// Deduplicating queue of open and close commands: pop on tick, append on add,
// slot read on read.
// ----------------------------------------------------------------------------
module dsq_cmd_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dsq_pkg::ctrl_type            ctrl,
   input  wire logic                         command,
   input  wire logic [dsq_pkg::INDEX_W-1:0]  entry_index,
   output dsq_pkg::head_type                 head,
   output logic      [dsq_pkg::COUNT_W-1:0]  count_next,
   output dsq_pkg::slot_type                 entry_value
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CMP_W = (CNT_W > dsq_pkg::INDEX_W) ? CNT_W : dsq_pkg::INDEX_W;

   dsq_pkg::slot_type slots_ff [QUEUE_DEPTH];
   dsq_pkg::slot_type slots_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   dsq_pkg::slot_type code;
   logic              dup;

   assign code = command ? dsq_pkg::SLOT_OPEN : dsq_pkg::SLOT_CLOSE;

   always_comb begin
      dup = 1'b0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if ((CNT_W'(k) < count_ff) && (slots_ff[k] == code)) begin
            dup = 1'b1;
         end
      end
   end

   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      if (ctrl.tick && (count_ff != '0)) begin
         for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            slots_in[k] = slots_ff[k+1];
         end
         slots_in[QUEUE_DEPTH-1] = dsq_pkg::SLOT_EMPTY;
         count_in = count_ff - CNT_W'(1);
      end else if (ctrl.add && !dup && (count_ff < CNT_W'(QUEUE_DEPTH))) begin
         slots_in[count_ff[IDX_W-1:0]] = code;
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slots_ff[k] <= dsq_pkg::SLOT_EMPTY;
         end
      end else begin
         count_ff <= count_in;
         slots_ff <= slots_in;
      end
   end

   assign head.valid   = (count_ff != '0);
   assign head.is_open = (slots_ff[0] == dsq_pkg::SLOT_OPEN);
   assign count_next   = dsq_pkg::COUNT_W'(count_in);

   always_comb begin
      entry_value = dsq_pkg::SLOT_EMPTY;
      if (ctrl.read && (CMP_W'(entry_index) < CMP_W'(count_ff))) begin
         entry_value = slots_ff[entry_index[IDX_W-1:0]];
      end
   end

endmodule
`default_nettype wire

### sv/dsq_door_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door sequencer state logic
// Door state with its opening, open and closing counters; applies the popped
// command, the timed advance and forced states.
// ----------------------------------------------------------------------------
module dsq_door_fsm (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dsq_pkg::ctrl_type            ctrl,
   input  wire dsq_pkg::head_type            head,
   input  wire logic [dsq_pkg::STATE_W-1:0]  new_state,
   input  wire logic [dsq_pkg::TICKS_W-1:0]  opening_ticks,
   input  wire logic [dsq_pkg::TICKS_W-1:0]  open_ticks,
   input  wire logic [dsq_pkg::TICKS_W-1:0]  closing_ticks,
   output logic      [dsq_pkg::STATE_W-1:0]  state_next
);

   logic [dsq_pkg::STATE_W-1:0] state_ff;
   logic [dsq_pkg::STATE_W-1:0] state_in;
   logic [dsq_pkg::STATE_W-1:0] mode;
   logic [dsq_pkg::TICKS_W-1:0] opening_cnt_ff;
   logic [dsq_pkg::TICKS_W-1:0] opening_cnt_in;
   logic [dsq_pkg::TICKS_W-1:0] open_cnt_ff;
   logic [dsq_pkg::TICKS_W-1:0] open_cnt_in;
   logic [dsq_pkg::TICKS_W-1:0] closing_cnt_ff;
   logic [dsq_pkg::TICKS_W-1:0] closing_cnt_in;

   always_comb begin
      mode           = state_ff;
      state_in       = state_ff;
      opening_cnt_in = opening_cnt_ff;
      open_cnt_in    = open_cnt_ff;
      closing_cnt_in = closing_cnt_ff;
      if (ctrl.tick) begin
         // apply popped command first
         if (head.valid) begin
            if (head.is_open) begin
               mode           = dsq_pkg::ST_OPENING;
               opening_cnt_in = '0;
            end else begin
               mode           = dsq_pkg::ST_CLOSING;
               closing_cnt_in = '0;
            end
         end
         state_in = mode;
         unique case (mode)
            dsq_pkg::ST_OPENING: begin
               if (opening_cnt_in == opening_ticks) begin
                  opening_cnt_in = '0;
                  state_in       = dsq_pkg::ST_OPEN;
               end else begin
                  opening_cnt_in = opening_cnt_in + 8'd1;
               end
            end
            dsq_pkg::ST_OPEN: begin
               if (open_cnt_in == open_ticks) begin
                  open_cnt_in = '0;
                  state_in    = dsq_pkg::ST_CLOSING;
               end else begin
                  open_cnt_in = open_cnt_in + 8'd1;
               end
            end
            dsq_pkg::ST_CLOSING: begin
               if (closing_cnt_in == closing_ticks) begin
                  closing_cnt_in = '0;
                  state_in       = dsq_pkg::ST_CLOSED;
               end else begin
                  closing_cnt_in = closing_cnt_in + 8'd1;
               end
            end
            dsq_pkg::ST_CLOSED: begin
               opening_cnt_in = '0;
               open_cnt_in    = '0;
               closing_cnt_in = '0;
            end
            default: begin
               state_in = mode;
            end
         endcase
      end else if (ctrl.set) begin
         state_in = (new_state > dsq_pkg::ST_UNKNOWN) ? dsq_pkg::ST_UNKNOWN : new_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dsq_pkg::ST_UNKNOWN;
         opening_cnt_ff <= '0;
         open_cnt_ff    <= '0;
         closing_cnt_ff <= '0;
      end else begin
         state_ff       <= state_in;
         opening_cnt_ff <= opening_cnt_in;
         open_cnt_ff    <= open_cnt_in;
         closing_cnt_ff <= closing_cnt_in;
      end
   end

   assign state_next = state_in;

endmodule
`default_nettype wire

### sv/dsq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door sequencer checker
// Port-level checks on result transactions of the door sequencer.
// ----------------------------------------------------------------------------
module dsq_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [dsq_pkg::STATE_W-1:0]  rsp_door_state,
   input wire logic [dsq_pkg::COUNT_W-1:0]  rsp_queue_count,
   input wire logic [dsq_pkg::SLOT_W-1:0]   rsp_entry_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_door_state)
         && $stable(rsp_queue_count) && $stable(rsp_entry_value))
      else $error("rsp transaction changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count != 2'd3 && rsp_entry_value != 2'd3
         && rsp_door_state <= dsq_pkg::ST_UNKNOWN)
      else $error("rsp field out of range");

   a_entry_needs_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_value != dsq_pkg::SLOT_EMPTY |-> rsp_queue_count != 2'd0)
      else $error("queue entry read from empty queue");

endmodule

bind door_sequencer_with_command_queue_top dsq_checker u_dsq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_door_state  (rsp_door_state),
   .rsp_queue_count (rsp_queue_count),
   .rsp_entry_value (rsp_entry_value)
);
`default_nettype wire
